@@ src/sorted_list_insert_delete_defines.svh @@
// Assertion macros for the sorted list block.
// Included by the modules that carry assertions; depends on nothing else.
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define SLID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sorted list assertion failed");
// A condition that forces a consequence at the next clock edge.
`define SLID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted list assertion failed");
`else
`define SLID_ASSERT(lbl, prop)
`define SLID_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ src/slid_pkg.sv @@
// Shared types and codes for the sorted list block.
// Used by slid_cell and sorted_list_insert_delete; depends on nothing.
package slid_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 5;

  // Request codes carried on the input tuser.
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LIST   = 2'd2;

  // Status codes carried on the output tuser.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } slid_op_e;

  typedef struct packed {
    slid_op_e                 op;
    logic signed [DATA_W-1:0] value;
  } slid_ctrl_t;

endpackage

@@ src/slid_cell.sv @@
// One cell of the sorted chain: holds a single entry and its comparators.
// Depends on slid_pkg.
module slid_cell (
  input  logic                                clk_i,
  input  slid_pkg::slid_ctrl_t                ctrl_i,
  input  logic                                occ_i,
  input  logic                                tail_i,
  input  logic                                left_le_i,
  input  logic signed [slid_pkg::DATA_W-1:0]  left_value_i,
  input  logic signed [slid_pkg::DATA_W-1:0]  right_value_i,
  input  logic signed [slid_pkg::DATA_W-1:0]  head_value_i,
  output logic signed [slid_pkg::DATA_W-1:0]  value_o,
  output logic                                le_o,
  output logic                                eq_o
);

  logic signed [slid_pkg::DATA_W-1:0] entry_q, entry_d;
  logic                               ge;

  // Comparisons of the stored entry against the broadcast value.
  assign le_o = occ_i && (entry_q <= ctrl_i.value);
  assign ge   = occ_i && (entry_q >= ctrl_i.value);
  assign eq_o = occ_i && (entry_q == ctrl_i.value);
  assign value_o = entry_q;

  // Next entry: keep, take the new value, or take a neighbour's entry.
  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      slid_pkg::OP_HOLD: begin
        entry_d = entry_q;
      end
      slid_pkg::OP_INSERT: begin
        if (le_o) begin
          entry_d = entry_q;
        end else if (left_le_i) begin
          entry_d = ctrl_i.value;
        end else begin
          entry_d = left_value_i;
        end
      end
      slid_pkg::OP_DELETE: begin
        entry_d = ge ? right_value_i : entry_q;
      end
      slid_pkg::OP_ROTATE: begin
        entry_d = tail_i ? head_value_i : right_value_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // Payload register; needs no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ src/sorted_list_insert_delete.sv @@
// Sorted list of signed values: top level with control and output register.
// Depends on slid_pkg, slid_cell and sorted_list_insert_delete_defines.svh.
//
// Usage: requests arrive on the s_axis channel, tuser holding the request
// (insert, delete, list) and tdata the value. Results leave on m_axis with
// the status in tuser, entry value and entry count in tdata, and tlast on
// the final result of a request.
// Insert and delete each give one result, in the cycle after the transfer; the
// whole chain of cells compares and shifts in the same cycle as the transfer, so a
// new insert or delete is taken every cycle while the receiver keeps up and no list is running.
// A request with an unused code is taken and gives no result.
// A list request gives one result per stored entry, lowest first, or one
// empty result on an empty list. The request enters the listing state, and
// the entries then leave one by one as the chain rotates them past the
// head cell; no new request is taken until the last entry has left.
// Reset empties the list at once; there is no clearing pass.
// When the receiver stalls, the output register holds its result and the
// input is not ready; nothing is lost or repeated.
`include "sorted_list_insert_delete_defines.svh"

module sorted_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] entry_value, [36:32] entry_count, zero fill
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Control state.
  logic [CNT_W-1:0] count_q, count_d;
  logic             list_q, list_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             out_valid_q, out_valid_d;

  // Output payload.
  logic [slid_pkg::STATUS_W-1:0]      out_status_q, out_status_d;
  logic signed [slid_pkg::DATA_W-1:0] out_value_q, out_value_d;
  logic [CNT_W-1:0]                   out_count_q, out_count_d;
  logic                               out_last_q, out_last_d;

  // Chain wiring.
  slid_pkg::slid_ctrl_t               ctrl;
  logic signed [slid_pkg::DATA_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]                cell_le;
  logic [CAPACITY-1:0]                cell_eq;
  logic                               found;
  logic                               full;
  logic                               take;
  logic                               accept;
  logic [CNT_W+slid_pkg::COUNT_OUT_W-1:0] count_ext;

  assign found  = |cell_eq;
  assign full   = (count_q == CNT_W'(CAPACITY));
  assign take   = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !list_q && take;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Row of cells; each cell sees its neighbours' entries and flags.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                               left_le;
    logic signed [slid_pkg::DATA_W-1:0] left_value;
    logic signed [slid_pkg::DATA_W-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_le    = 1'b1;
      assign left_value = ctrl.value;
    end else begin : g_inner
      assign left_le    = cell_le[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    slid_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (count_q > CNT_W'(i)),
      .tail_i        (count_q == CNT_W'(i + 1)),
      .left_le_i     (left_le),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .head_value_i  (cell_value[0]),
      .value_o       (cell_value[i]),
      .le_o          (cell_le[i]),
      .eq_o          (cell_eq[i])
    );
  end

  // Request handling, list sequencing and output register loading.
  always_comb begin
    count_d      = count_q;
    list_d       = list_q;
    rem_d        = rem_q;
    out_valid_d  = take ? 1'b0 : out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    ctrl.op      = slid_pkg::OP_HOLD;
    ctrl.value   = $signed(s_axis_tdata);

    priority if (list_q && take) begin
      // Emit the head entry and rotate the chain by one place.
      out_valid_d  = 1'b1;
      out_status_d = slid_pkg::ST_OK;
      out_value_d  = cell_value[0];
      out_count_d  = count_q;
      out_last_d   = (rem_q == CNT_W'(1));
      ctrl.op      = slid_pkg::OP_ROTATE;
      rem_d        = rem_q - 1'b1;
      if (rem_q == CNT_W'(1)) begin
        list_d = 1'b0;
      end
    end else if (accept) begin
      unique case (s_axis_tuser)
        slid_pkg::REQ_INSERT: begin
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_last_d   = 1'b1;
          if (full) begin
            out_status_d = slid_pkg::ST_FULL;
            out_count_d  = count_q;
          end else begin
            ctrl.op      = slid_pkg::OP_INSERT;
            count_d      = count_q + 1'b1;
            out_status_d = slid_pkg::ST_OK;
            out_count_d  = count_q + 1'b1;
          end
        end
        slid_pkg::REQ_DELETE: begin
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_last_d   = 1'b1;
          if (found) begin
            ctrl.op      = slid_pkg::OP_DELETE;
            count_d      = count_q - 1'b1;
            out_status_d = slid_pkg::ST_OK;
            out_count_d  = count_q - 1'b1;
          end else begin
            out_status_d = slid_pkg::ST_NOT_FOUND;
            out_count_d  = count_q;
          end
        end
        slid_pkg::REQ_LIST: begin
          if (count_q == '0) begin
            out_valid_d  = 1'b1;
            out_status_d = slid_pkg::ST_EMPTY;
            out_value_d  = '0;
            out_count_d  = '0;
            out_last_d   = 1'b1;
          end else begin
            list_d = 1'b1;
            rem_d  = count_q;
          end
        end
        default: begin
          // Unused request code: taken and dropped.
        end
      endcase
    end else begin
      // Nothing to load this cycle.
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      list_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      list_q      <= list_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload registers.
  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  // Output packing; the count is reported modulo 32.
  assign count_ext     = {{slid_pkg::COUNT_OUT_W{1'b0}}, out_count_q};
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'b000, count_ext[slid_pkg::COUNT_OUT_W-1:0], out_value_q};

  // The entry count never exceeds the capacity.
  `SLID_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY))
  // While listing, the entries still to go are between one and the count.
  `SLID_ASSERT(a_rem_range, !list_q || (rem_q != '0 && rem_q <= count_q))
  // An accepted insert into a list with room grows the count by one.
  `SLID_ASSERT_NEXT(a_insert_grows,
    accept && s_axis_tuser == slid_pkg::REQ_INSERT && !full,
    count_q == $past(count_q) + 1'b1)
  // The final entry of a listing ends the listing and is marked last.
  `SLID_ASSERT_NEXT(a_list_ends, list_q && take && rem_q == CNT_W'(1),
    !list_q && out_valid_q && out_last_q)

endmodule
